[sv/gn3_pkg.sv]
// Shared types and constants of the 3-D gradient noise block.
package gn3_pkg;

    // Default configuration
    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed field widths
    localparam int COORD_W = 32;
    localparam int ENTRY_W = 8;
    localparam int OUT_W   = 19;
    localparam int HASH_W  = 4;
    localparam int N_CORNER = 8;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Gradient selection thresholds on the low hash nibble
    localparam logic [HASH_W-1:0] HASH_U_FROM_Y = 4'd8;
    localparam logic [HASH_W-1:0] HASH_V_FROM_Y = 4'd4;
    localparam logic [HASH_W-1:0] HASH_V_X_LO   = 4'd12;
    localparam logic [HASH_W-1:0] HASH_V_X_HI   = 4'd14;

    // Main sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FADE,
        S_GRAD,
        S_LERP
    } t_state;

    // Table read schedule: one address per step, read data arrives in the next step
    typedef enum logic [3:0] {
        H_X,
        H_X1,
        H_A,
        H_A1,
        H_B,
        H_B1,
        H_AA,
        H_AA1,
        H_AB,
        H_AB1,
        H_BA,
        H_BA1,
        H_BB,
        H_BB1,
        H_LAST
    } t_hstep;

    // Requests from the main sequencer to the hash unit
    typedef struct packed {
        logic start;
        logic wr;
    } t_hash_req;

endpackage

[sv/gn3_mulq.sv]
// Shared fixed-point multiplier: registered product, round half away from zero.
module gn3_mulq #(
    parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic signed [FRAC_BITS+4:0] i_a,
    input  logic        [FRAC_BITS:0]   i_t,
    output logic signed [FRAC_BITS+4:0] o_m
);

    localparam int DW = FRAC_BITS + 5;
    localparam int TW = FRAC_BITS + 1;
    localparam int PW = DW + TW;
    localparam logic [PW-1:0] L_HALF = PW'(1) << (FRAC_BITS - 1);

    logic [DW-1:0] w_mag;
    logic [PW-1:0] r_prod;
    logic          r_neg;
    logic [PW-1:0] w_rnd;

    // t is never negative, so the sign follows the first operand alone
    assign w_mag = i_a[DW-1] ? DW'(-i_a) : DW'(i_a);

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_mag) * PW'(i_t);
        r_neg  <= i_a[DW-1];
    end

    assign w_rnd = (r_prod + L_HALF) >> FRAC_BITS;
    assign o_m   = r_neg ? -$signed(w_rnd[DW-1:0]) : $signed(w_rnd[DW-1:0]);

endmodule

[sv/gn3_hash.sv]
// Permutation table and corner hash sequencer.
module gn3_hash #(
    parameter int TABLE_SIZE = gn3_pkg::TABLE_SIZE_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  gn3_pkg::t_hash_req                            i_req,
    input  logic [gn3_pkg::ENTRY_W-1:0]                   i_wr_idx,
    input  logic [gn3_pkg::ENTRY_W-1:0]                   i_wr_val,
    input  logic [$clog2(TABLE_SIZE)-1:0]                 i_cell_x,
    input  logic [$clog2(TABLE_SIZE)-1:0]                 i_cell_y,
    input  logic [$clog2(TABLE_SIZE)-1:0]                 i_cell_z,
    output logic                                          o_valid,
    output logic [gn3_pkg::N_CORNER-1:0][gn3_pkg::HASH_W-1:0] o_hash
);

    import gn3_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);

    logic [ENTRY_W-1:0] r_mem [TABLE_SIZE];
    logic [ENTRY_W-1:0] r_rd;
    logic [AW-1:0]      w_addr;

    t_hstep        r_step;
    logic          r_run;
    logic          r_valid;
    logic [AW-1:0] r_cx, r_cy, r_cz;
    logic [AW-1:0] r_ha, r_hb, r_aa, r_ab, r_ba, r_bb;
    logic [N_CORNER-1:0][HASH_W-1:0] r_h;
    logic [AW-1:0] w_plus_y, w_plus_z;

    // Table port: one write and one read a cycle, read data registered
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[AW'(i_wr_idx)] <= i_wr_val;
        end
        r_rd <= r_mem[w_addr];
    end

    always_comb begin
        case (r_step)
            H_X:     w_addr = r_cx;
            H_X1:    w_addr = r_cx + AW'(1);
            H_A:     w_addr = r_ha;
            H_A1:    w_addr = r_ha + AW'(1);
            H_B:     w_addr = r_hb;
            H_B1:    w_addr = r_hb + AW'(1);
            H_AA:    w_addr = r_aa;
            H_AA1:   w_addr = r_aa + AW'(1);
            H_AB:    w_addr = r_ab;
            H_AB1:   w_addr = r_ab + AW'(1);
            H_BA:    w_addr = r_ba;
            H_BA1:   w_addr = r_ba + AW'(1);
            H_BB:    w_addr = r_bb;
            H_BB1:   w_addr = r_bb + AW'(1);
            default: w_addr = r_cx;
        endcase
    end

    assign w_plus_y = AW'(r_rd) + r_cy;
    assign w_plus_z = AW'(r_rd) + r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_valid <= 1'b0;
            r_step  <= H_X;
        end else if (i_req.start) begin
            r_run   <= 1'b1;
            r_valid <= 1'b0;
            r_step  <= H_X;
        end else if (r_run) begin
            if (r_step == H_LAST) begin
                r_run   <= 1'b0;
                r_valid <= 1'b1;
            end else begin
                r_step <= t_hstep'(r_step + 4'd1);
            end
        end
    end

    // Latch the cells on start; capture the read issued in the previous step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cx <= i_cell_x;
            r_cy <= i_cell_y;
            r_cz <= i_cell_z;
        end
        if (r_run) begin
            case (r_step)
                H_X1:    r_ha   <= w_plus_y;
                H_A:     r_hb   <= w_plus_y;
                H_A1:    r_aa   <= w_plus_z;
                H_B:     r_ab   <= w_plus_z;
                H_B1:    r_ba   <= w_plus_z;
                H_AA:    r_bb   <= w_plus_z;
                H_AA1:   r_h[0] <= r_rd[HASH_W-1:0];
                H_AB:    r_h[4] <= r_rd[HASH_W-1:0];
                H_AB1:   r_h[2] <= r_rd[HASH_W-1:0];
                H_BA:    r_h[6] <= r_rd[HASH_W-1:0];
                H_BA1:   r_h[1] <= r_rd[HASH_W-1:0];
                H_BB:    r_h[5] <= r_rd[HASH_W-1:0];
                H_BB1:   r_h[3] <= r_rd[HASH_W-1:0];
                H_LAST:  r_h[7] <= r_rd[HASH_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_hash  = r_h;

endmodule

[sv/gradient_noise_3d.sv]
// Top level of the 3-D gradient noise block: sequencer, fade and blend datapath.
// A query runs its 12 fade products, the gradient step and then its 7 blend products,
// each product through the one shared multiplier, issued and then collected from its output
// register, and returns its result on o_valid. busy stays high until the result appears,
// so a new query is taken only after the last result. Table writes go back to back.
// Reset clears the sequencer only; the permutation table holds garbage until written.
module gradient_noise_3d #(
    parameter int TABLE_SIZE = gn3_pkg::TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = gn3_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_func,
    input  logic [gn3_pkg::ENTRY_W-1:0]        i_entry_index,
    input  logic [gn3_pkg::ENTRY_W-1:0]        i_entry_value,
    input  logic signed [gn3_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [gn3_pkg::COORD_W-1:0] i_y_coord,
    input  logic signed [gn3_pkg::COORD_W-1:0] i_z_coord,
    output logic                               o_valid,
    output logic signed [gn3_pkg::OUT_W-1:0]   o_noise_value
);

    import gn3_pkg::*;

    // TABLE_SIZE is a power of two; cells and hashes wrap in AW bits
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int DW = FRAC_BITS + 5;   // signed working width, -16.0 up to just under +16.0
    localparam int TW = FRAC_BITS + 1;   // blend weight, 0.0 to 1.0 inclusive

    localparam logic signed [DW-1:0] L_ONE     = DW'(1 << FRAC_BITS);
    localparam logic signed [DW-1:0] L_TWO     = DW'(2 << FRAC_BITS);
    localparam logic signed [DW-1:0] L_TEN     = DW'(10 * (1 << FRAC_BITS));
    localparam logic signed [DW-1:0] L_FIFTEEN = DW'(15 * (1 << FRAC_BITS));

    localparam logic [1:0] FSTEP_POLY = 2'd0;
    localparam logic [1:0] FSTEP_LAST = 2'd3;
    localparam logic [1:0] AXIS_LAST  = 2'd2;
    localparam logic [2:0] LERP_V_1ST = 3'd4;
    localparam logic [2:0] LERP_W_1ST = 3'd6;
    localparam logic [2:0] LERP_LAST  = 3'd6;

    // Sequencer
    t_state r_state, n_state;
    logic       r_ph;      // 0: issue product, 1: collect it
    logic [1:0] r_axis;
    logic [1:0] r_fstep;
    logic [2:0] r_lerp;
    logic       r_out_vld;

    // Datapath
    logic [FRAC_BITS-1:0]   r_frac [3];
    logic [TW-1:0]          r_fade [3];
    logic signed [DW-1:0]   r_acc;
    logic signed [DW-1:0]   r_val [N_CORNER];
    logic signed [DW-1:0]   r_la;
    logic signed [OUT_W-1:0] r_noise;

    t_hash_req w_hreq;
    logic      w_query_go;
    logic      w_hash_vld;
    logic [N_CORNER-1:0][HASH_W-1:0] w_hash;

    logic signed [COORD_W-1:0] w_fx, w_fy, w_fz;
    logic signed [DW-1:0] w_mul_a, w_mul_m, w_tx, w_sum, w_sat;
    logic [TW-1:0]        w_mul_t, w_fade_c;
    logic signed [DW-1:0] w_grad [N_CORNER];
    logic signed [DW-1:0] w_p0 [3];
    logic signed [DW-1:0] w_p1 [3];
    logic [2:0]           w_widx;

    function automatic logic signed [DW-1:0] grad_f(
        input logic [HASH_W-1:0] h,
        input logic signed [DW-1:0] gx,
        input logic signed [DW-1:0] gy,
        input logic signed [DW-1:0] gz
    );
        logic signed [DW-1:0] gu;
        logic signed [DW-1:0] gv;
        gu = (h < HASH_U_FROM_Y) ? gx : gy;
        gv = (h < HASH_V_FROM_Y) ? gy :
             ((h == HASH_V_X_LO || h == HASH_V_X_HI) ? gx : gz);
        return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    endfunction

    // Integer cell of each coordinate: floor, wrapped to the table
    assign w_fx = i_x_coord >>> FRAC_BITS;
    assign w_fy = i_y_coord >>> FRAC_BITS;
    assign w_fz = i_z_coord >>> FRAC_BITS;

    gn3_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_hreq),
        .i_wr_idx (i_entry_index),
        .i_wr_val (i_entry_value),
        .i_cell_x (w_fx[AW-1:0]),
        .i_cell_y (w_fy[AW-1:0]),
        .i_cell_z (w_fz[AW-1:0]),
        .o_valid  (w_hash_vld),
        .o_hash   (w_hash)
    );

    gn3_mulq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_t   (w_mul_t),
        .o_m   (w_mul_m)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && i_func == FUNC_QUERY) n_state = S_FADE;
            end
            S_FADE: begin
                if (r_ph && r_fstep == FSTEP_LAST && r_axis == AXIS_LAST) n_state = S_GRAD;
            end
            S_GRAD: begin
                if (w_hash_vld) n_state = S_LERP;
            end
            S_LERP: begin
                if (r_ph && r_lerp == LERP_LAST) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        busy         = 1'b1;
        w_hreq.start = 1'b0;
        w_hreq.wr    = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy         = 1'b0;
                w_hreq.start = start && (i_func == FUNC_QUERY);
                w_hreq.wr    = start && (i_func == FUNC_WRITE);
            end
            default: busy = 1'b1;
        endcase
    end

    assign w_query_go = w_hreq.start;

    // Shared multiplier operands
    always_comb begin
        w_tx = $signed({5'b0, r_frac[r_axis]});
        if (r_state == S_LERP) begin
            w_mul_a = r_val[1] - r_val[0];
            if (r_lerp < LERP_V_1ST) begin
                w_mul_t = r_fade[0];
            end else if (r_lerp < LERP_W_1ST) begin
                w_mul_t = r_fade[1];
            end else begin
                w_mul_t = r_fade[2];
            end
        end else begin
            w_mul_t = {1'b0, r_frac[r_axis]};
            // Horner: t * (6t - 15) first, then repeated t * acc
            w_mul_a = (r_fstep == FSTEP_POLY) ?
                      (w_tx <<< 2) + (w_tx <<< 1) - L_FIFTEEN : r_acc;
        end
    end

    // Clamp the fade curve to 0.0 .. 1.0
    always_comb begin
        if (w_mul_m < 0) begin
            w_fade_c = '0;
        end else if (w_mul_m > L_ONE) begin
            w_fade_c = L_ONE[TW-1:0];
        end else begin
            w_fade_c = w_mul_m[TW-1:0];
        end
    end

    // Corner gradients: bit 0 picks x-1, bit 1 y-1, bit 2 z-1
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_p0[a] = $signed({5'b0, r_frac[a]});
            w_p1[a] = w_p0[a] - L_ONE;
        end
        for (int i = 0; i < N_CORNER; i++) begin
            w_grad[i] = grad_f(w_hash[i],
                               ((i & 1) != 0) ? w_p1[0] : w_p0[0],
                               ((i & 2) != 0) ? w_p1[1] : w_p0[1],
                               ((i & 4) != 0) ? w_p1[2] : w_p0[2]);
        end
    end

    // Blend result and output saturation to +-2.0
    assign w_sum  = r_la + w_mul_m;
    assign w_sat  = (w_sum > L_TWO) ? L_TWO : ((w_sum < -L_TWO) ? -L_TWO : w_sum);
    // Each blend eats two values from the head; its result joins the tail
    assign w_widx = LERP_LAST - r_lerp;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ph      <= 1'b0;
            r_axis    <= '0;
            r_fstep   <= '0;
            r_lerp    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_ph    <= 1'b0;
                    r_axis  <= '0;
                    r_fstep <= '0;
                    r_lerp  <= '0;
                end
                S_FADE: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_fstep <= r_fstep + 2'd1;
                        if (r_fstep == FSTEP_LAST) r_axis <= r_axis + 2'd1;
                    end
                end
                S_LERP: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_lerp <= r_lerp + 3'd1;
                        if (r_lerp == LERP_LAST) r_out_vld <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_query_go) begin
            r_frac[0] <= i_x_coord[FRAC_BITS-1:0];
            r_frac[1] <= i_y_coord[FRAC_BITS-1:0];
            r_frac[2] <= i_z_coord[FRAC_BITS-1:0];
        end
        case (r_state)
            S_FADE: begin
                if (r_ph) begin
                    case (r_fstep)
                        FSTEP_POLY: r_acc <= w_mul_m + L_TEN;
                        FSTEP_LAST: r_fade[r_axis] <= w_fade_c;
                        default:    r_acc <= w_mul_m;
                    endcase
                end
            end
            S_GRAD: begin
                if (w_hash_vld) begin
                    for (int i = 0; i < N_CORNER; i++) r_val[i] <= w_grad[i];
                end
            end
            S_LERP: begin
                if (!r_ph) begin
                    // Hold the low end, advance the queue by two
                    r_la <= r_val[0];
                    for (int i = 0; i < N_CORNER - 2; i++) r_val[i] <= r_val[i+2];
                end else begin
                    r_val[w_widx] <= w_sum;
                    if (r_lerp == LERP_LAST) r_noise <= OUT_W'(COORD_W'(w_sat));
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_out_vld;
    assign o_noise_value = r_noise;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the 3-D gradient noise block: table loads and noise queries.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gn3_pkg::*;

    localparam int      CLK_HALF     = 10;
    localparam int      CYCLE_LIMIT  = 600000;  // watchdog bound for a hung run
    localparam int      DRAIN_CYCLES = 60;      // idle cycles after the last result
    localparam int      MAX_REPORTS  = 10;
    localparam int      RAND_CHUNKS  = 9;
    localparam int      CHUNK_ITEMS  = 100;
    localparam longint  FIX_ONE      = longint'(1) << FRAC_BITS_DEF;
    localparam longint  FIX_HALF     = longint'(1) << (FRAC_BITS_DEF - 1);

    // Clock, reset and every block input start at known values.
    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       start         = 1'b0;
    logic                       i_func        = FUNC_WRITE;
    logic [ENTRY_W-1:0]         i_entry_index = '0;
    logic [ENTRY_W-1:0]         i_entry_value = '0;
    logic signed [COORD_W-1:0]  i_x_coord     = '0;
    logic signed [COORD_W-1:0]  i_y_coord     = '0;
    logic signed [COORD_W-1:0]  i_z_coord     = '0;
    logic                       busy;
    logic                       o_valid;
    logic signed [OUT_W-1:0]    o_noise_value;

    // Shadow of the permutation table and the noise values still owed by the block.
    logic [ENTRY_W-1:0]         shadow_perm [256];
    logic [OUT_W-1:0]           noise_expected [$];
    int                         error_count = 0;
    int                         cycle_count = 0;
    bit                         no_gap      = 1'b0;

    gradient_noise_3d u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_z_coord     (i_z_coord),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Fixed-point noise predictor
    // ------------------------------------------------------------------

    // Q16 product, rounded to nearest with ties away from zero.
    function automatic longint fix_mul(longint a, longint b);
        logic            neg;
        longint unsigned ma, mb, m;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? longint'(-a) : a;
        mb  = (b < 0) ? longint'(-b) : b;
        m   = (ma * mb + FIX_HALF) >> FRAC_BITS_DEF;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Fade curve 6t^5 - 15t^4 + 10t^3 by Horner's rule, rounding after every product.
    function automatic longint fade_of(longint t);
        longint p, r;
        p = fix_mul(t, 6 * t - 15 * FIX_ONE) + 10 * FIX_ONE;
        r = fix_mul(t, fix_mul(t, fix_mul(t, p)));
        if (r < 0) r = 0;
        if (r > FIX_ONE) r = FIX_ONE;
        return r;
    endfunction

    function automatic longint blend(longint t, longint a, longint b);
        return a + fix_mul(t, b - a);
    endfunction

    // Pick one of the edge gradients from the low hash nibble and dot it with the offset.
    function automatic longint corner_dot(logic [ENTRY_W-1:0] hash, longint x, longint y,
                                          longint z);
        logic [HASH_W-1:0] h;
        longint            u, v;
        h = hash[HASH_W-1:0];
        u = (h < HASH_U_FROM_Y) ? x : y;
        if (h < HASH_V_FROM_Y)
            v = y;
        else if (h == HASH_V_X_LO || h == HASH_V_X_HI)
            v = x;
        else
            v = z;
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // Noise at one point. Cell modulo 256 is bits 23:16 of the coordinate, fraction bits 15:0.
    function automatic logic [OUT_W-1:0] noise_at(logic [COORD_W-1:0] xr, logic [COORD_W-1:0] yr,
                                                  logic [COORD_W-1:0] zr);
        logic [ENTRY_W-1:0] cx, cy, cz, a, aa, ab, b, ba, bb;
        longint             x, y, z, x1, y1, z1, u, v, w, r;
        cx = xr[23:16];
        cy = yr[23:16];
        cz = zr[23:16];
        x  = longint'(xr[15:0]);
        y  = longint'(yr[15:0]);
        z  = longint'(zr[15:0]);
        u  = fade_of(x);
        v  = fade_of(y);
        w  = fade_of(z);
        x1 = x - FIX_ONE;
        y1 = y - FIX_ONE;
        z1 = z - FIX_ONE;
        // Hash the eight corners; all index sums wrap at 8 bits.
        a  = shadow_perm[cx] + cy;
        aa = shadow_perm[a] + cz;
        ab = shadow_perm[ENTRY_W'(a + 1)] + cz;
        b  = shadow_perm[ENTRY_W'(cx + 1)] + cy;
        ba = shadow_perm[b] + cz;
        bb = shadow_perm[ENTRY_W'(b + 1)] + cz;
        r = blend(w,
                blend(v, blend(u, corner_dot(shadow_perm[aa], x, y, z),
                                  corner_dot(shadow_perm[ba], x1, y, z)),
                         blend(u, corner_dot(shadow_perm[ab], x, y1, z),
                                  corner_dot(shadow_perm[bb], x1, y1, z))),
                blend(v, blend(u, corner_dot(shadow_perm[ENTRY_W'(aa + 1)], x, y, z1),
                                  corner_dot(shadow_perm[ENTRY_W'(ba + 1)], x1, y, z1)),
                         blend(u, corner_dot(shadow_perm[ENTRY_W'(ab + 1)], x, y1, z1),
                                  corner_dot(shadow_perm[ENTRY_W'(bb + 1)], x1, y1, z1))));
        // Saturate to +-2.0 before taking the output width.
        if (r > 2 * FIX_ONE) r = 2 * FIX_ONE;
        if (r < -2 * FIX_ONE) r = -2 * FIX_ONE;
        return r[OUT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict at every accepted transfer, check every result strobe
    // ------------------------------------------------------------------

    task automatic log_mismatch(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s, expected %h, got %h",
                     cycle_count, what, want, got);
    endtask

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (i_rst_n) begin
            // Check first: a result leaving on this edge belongs to an older query.
            if (o_valid) begin
                if (noise_expected.size() == 0) begin
                    log_mismatch("result with no query pending", 'x, o_noise_value);
                end else begin
                    want = noise_expected.pop_front();
                    if (o_noise_value !== want)
                        log_mismatch("noise_value", want, o_noise_value);
                end
            end
            if (start && !busy) begin
                if (i_func == FUNC_WRITE)
                    shadow_perm[i_entry_index] = i_entry_value;
                else
                    noise_expected.push_back(noise_at(i_x_coord, i_y_coord, i_z_coord));
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Drive one item and hold it until the block takes the transfer. Enter and leave
    // just after a rising edge; start stays high when the next item follows with no gap.
    task automatic send_item(logic func, logic [ENTRY_W-1:0] idx, logic [ENTRY_W-1:0] val,
                             logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= func;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_x_coord     <= x;
        i_y_coord     <= y;
        i_z_coord     <= z;
        do @(posedge i_clk); while (busy);
    endtask

    // Table write; the coordinate ports carry junk that the block must ignore.
    task automatic send_write(logic [ENTRY_W-1:0] idx, logic [ENTRY_W-1:0] val);
        send_item(FUNC_WRITE, idx, val, $urandom, $urandom, $urandom);
    endtask

    // Noise query; the table ports carry junk that the block must ignore.
    task automatic send_query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z);
        send_item(FUNC_QUERY, ENTRY_W'($urandom), ENTRY_W'($urandom), x, y, z);
    endtask

    // Random coordinate: full range, near the origin, or with an extreme fraction.
    function automatic logic [COORD_W-1:0] pick_coord();
        logic [COORD_W-1:0] c;
        case ($urandom_range(0, 3))
            0: c = COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            1: begin
                c = $urandom;
                c[15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            default: c = $urandom;
        endcase
        return c;
    endfunction

    // Load the whole table with a shuffled permutation, so no query ever reads an
    // unwritten entry. Covers index and value extremes on the way.
    task automatic test_table_load();
        logic [ENTRY_W-1:0] order [256];
        logic [ENTRY_W-1:0] swap;
        int                 j;
        for (int i = 0; i < 256; i++)
            order[i] = ENTRY_W'(i);
        for (int i = 255; i > 0; i--) begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (int i = 0; i < 256; i++)
            send_write(ENTRY_W'(i), order[i]);
    endtask

    // Coordinate extremes: most negative and positive values, zero and all-ones fractions,
    // negative points whose cell wraps below zero, and cell 255 whose neighbor is cell 0.
    task automatic test_coord_extremes();
        logic [COORD_W-1:0] edges [8];
        edges = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h00FF_8000};
        for (int i = 0; i < 8; i++)
            send_query(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
    endtask

    // Rewrite both end entries back to back with value extremes, then query next to them.
    task automatic test_table_rewrite();
        no_gap = 1'b1;
        send_write(8'd255, 8'd0);
        send_write(8'd0, 8'd255);
        no_gap = 1'b0;
        send_query(32'h00FF_0000, 32'h00FF_FFFF, 32'hFFFF_8000);
        send_query(32'hFFFF_FFFF, 32'h0000_0001, 32'h00FF_0000);
        send_query(32'h0100_0000, 32'hFF00_0000, 32'hFFFF_FFFF);
    endtask

    // Random mix of queries and table writes; some chunks run with no gaps at all.
    task automatic test_random_mix();
        for (int c = 0; c < RAND_CHUNKS; c++) begin
            no_gap = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < CHUNK_ITEMS; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send_write(ENTRY_W'($urandom), ENTRY_W'($urandom));
                else
                    send_query(pick_coord(), pick_coord(), pick_coord());
            end
        end
        no_gap = 1'b0;
    endtask

    initial begin
        // Hold reset from time zero, release it on a rising edge.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_coord_extremes();
        test_table_rewrite();
        test_random_mix();

        // Drop start, let the last transfer's expectation land, then drain.
        start <= 1'b0;
        @(posedge i_clk);
        while (noise_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
